[design/wrlm_pkg.sv]
// Package for the windowed RMS level meter.
// Holds the widths, constants, codes, sequencer states and shared-unit structs.
// No dependencies.
package wrlm_pkg;

  // Window and field sizes
  localparam int MAX_WINDOW = 800;
  localparam int SAMPLE_W   = 16;
  localparam int CMD_W      = 2;
  localparam int SUM_W      = 40;
  localparam int CNT_W      = 10;
  localparam int LEVEL_W    = 10;

  // Shared unit operand sizes
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W   = 31;
  localparam int ROOT_W = 32;
  localparam int P_W    = 26;
  localparam int Q_W    = P_W - 15;
  localparam int R0_W   = 16;

  // Level scaling constants
  localparam int FULL_SCALE = 32767;
  localparam int LEVEL_MAX  = 1000;

  // Iteration counts of the long operations
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_DIV,
    S_SQRT,
    S_MUL,
    S_ADD,
    S_CMP,
    S_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [SUM_W-1:0]   a;
    logic [SUM_W-1:0]   b;
    logic [MUL_W-1:0]   ma;
    logic [MUL_W-1:0]   mb;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]   res;
    logic               borrow;
    logic [PROD_W-1:0]  prod;
  } alu_rsp_t;

endpackage

[design/wrlm_alu.sv]
// Shared arithmetic unit: one 40-bit adder/subtractor and one 17x17 multiplier.
// Depends on wrlm_pkg.
module wrlm_alu import wrlm_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [SUM_W-1:0] b_in;
  logic             cin;
  logic [SUM_W:0]   total;

  // Invert and add one for a subtract
  assign b_in  = (req.op == ALU_SUB) ? ~req.b : req.b;
  assign cin   = (req.op == ALU_SUB);
  assign total = {1'b0, req.a} + {1'b0, b_in} + {{SUM_W{1'b0}}, cin};

  assign rsp.res    = total[SUM_W-1:0];
  assign rsp.borrow = (req.op == ALU_SUB) & ~total[SUM_W];
  assign rsp.prod   = req.ma * req.mb;

endmodule

[design/wrlm_outbuf.sv]
// Output register that holds one finished level while the consumer stalls.
// Depends on wrlm_pkg.
module wrlm_outbuf import wrlm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  logic [LEVEL_W-1:0] res_level,
  output logic               res_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] level
);

  logic               valid_q;
  logic [LEVEL_W-1:0] level_q;

  // Refuse a new level only while the held one is stalled
  assign res_stall = valid_q & out_stall;

  // Load a new item, or drop the held one once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (res_valid && !res_stall) begin
      valid_q <= 1'b1;
    end else if (!out_stall) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && !res_stall) begin
      level_q <= res_level;
    end
  end

  assign out_valid = valid_q;
  assign level     = level_q;

endmodule

[design/wrlm_seq.sv]
// Sequencer and window state: accumulates squares, then divides, takes the
// root and scales it, step by step through the shared unit.
// Depends on wrlm_pkg.
module wrlm_seq import wrlm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    command,
  input  logic signed [SAMPLE_W-1:0] sample,
  output alu_req_t            alu_req,
  input  alu_rsp_t            alu_rsp,
  output logic                res_valid,
  output logic [LEVEL_W-1:0]  res_level,
  input  logic                res_stall
);

  state_t state, state_next;

  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   count;
  logic [MUL_W-1:0]   mag;
  logic               close_req;
  logic [SQ_W-1:0]    square;
  logic [SUM_W-1:0]   quo;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   divisor;
  logic [ROOT_W-1:0]  v;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  bitpos;
  logic [P_W-1:0]     p;
  logic [R0_W-1:0]    r0;
  logic [STEP_W-1:0]  step;
  logic [LEVEL_W-1:0] level_q;

  logic               accept;
  logic               is_clear;
  logic [MUL_W-1:0]   sample_ext;
  logic [MUL_W-1:0]   mag_in;
  logic [CNT_W-1:0]   cnt_inc;
  logic               win_close;
  logic [CNT_W:0]     trial;
  logic [SUM_W-1:0]   quo_final;
  logic [Q_W-1:0]     q0;
  logic [Q_W-1:0]     q_fin;
  logic               div_last;
  logic               sqrt_last;

  assign accept   = in_valid & ~in_stall;
  assign is_clear = (command >= CMD_CLEAR);

  // Magnitude of the sample, exact for the most negative code
  assign sample_ext = {sample[SAMPLE_W-1], sample};
  assign mag_in     = sample[SAMPLE_W-1] ? (~sample_ext + MUL_W'(1)) : sample_ext;

  assign cnt_inc   = count + CNT_W'(1);
  assign win_close = close_req || (cnt_inc >= CNT_W'(MAX_WINDOW)) || (cnt_inc == '1);

  // Restoring divide step: shift in the next dividend bit
  assign trial     = {rem, quo[SUM_W-1]};
  assign quo_final = {quo[SUM_W-2:0], ~alu_rsp.borrow};

  // Scale by 1000/32767: p = q0 * 32767 + r0 with r0 = p mod 32768 + q0
  assign q0    = p[P_W-1:15];
  assign q_fin = q0 + Q_W'(!alu_rsp.borrow);

  assign div_last  = (step == STEP_W'(DIV_STEPS - 1));
  assign sqrt_last = (step == STEP_W'(SQRT_STEPS - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = is_clear ? S_DONE : S_SQUARE;
        end
      end
      S_SQUARE: state_next = S_ACCUM;
      S_ACCUM:  state_next = win_close ? S_DIV : S_IDLE;
      S_DIV: begin
        if (div_last) begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL:  state_next = S_ADD;
      S_ADD:  state_next = S_CMP;
      S_CMP:  state_next = S_DONE;
      S_DONE: begin
        if (!res_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and shared unit operands
  always_comb begin
    in_stall   = 1'b1;
    res_valid  = 1'b0;
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    alu_req.ma = mag;
    alu_req.mb = mag;
    case (state)
      S_IDLE: in_stall = 1'b0;
      S_SQUARE: begin
        alu_req.ma = mag;
        alu_req.mb = mag;
      end
      S_ACCUM: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = sum;
        alu_req.b  = SUM_W'(square);
      end
      S_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = SUM_W'(trial);
        alu_req.b  = SUM_W'(divisor);
      end
      S_SQRT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = SUM_W'(v);
        alu_req.b  = SUM_W'(root | bitpos);
      end
      S_MUL: begin
        alu_req.ma = root[MUL_W-1:0];
        alu_req.mb = MUL_W'(LEVEL_MAX);
      end
      S_ADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = SUM_W'(p[14:0]);
        alu_req.b  = SUM_W'(q0);
      end
      S_CMP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = SUM_W'(r0);
        alu_req.b  = SUM_W'(FULL_SCALE);
      end
      S_DONE: res_valid = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  assign res_level = level_q;

  // State register and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sum   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept && is_clear) begin
            sum   <= '0;
            count <= '0;
          end
        end
        S_ACCUM: begin
          if (win_close) begin
            sum   <= '0;
            count <= '0;
          end else begin
            sum   <= alu_rsp.res;
            count <= cnt_inc;
          end
        end
        default: begin
          sum   <= sum;
          count <= count;
        end
      endcase
    end
  end

  // Working registers of the long operations
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        mag       <= mag_in;
        close_req <= (command == CMD_CLOSE);
        level_q   <= '0;
      end
      S_SQUARE: square <= alu_rsp.prod[SQ_W-1:0];
      S_ACCUM: begin
        quo     <= alu_rsp.res;
        rem     <= '0;
        divisor <= cnt_inc;
        step    <= '0;
      end
      S_DIV: begin
        quo  <= quo_final;
        rem  <= alu_rsp.borrow ? trial[CNT_W-1:0] : alu_rsp.res[CNT_W-1:0];
        step <= div_last ? '0 : step + STEP_W'(1);
        if (div_last) begin
          // Clamp the mean to 32 bits and set up the root
          v      <= (quo_final[SUM_W-1:ROOT_W] != '0) ? '1 : quo_final[ROOT_W-1:0];
          root   <= '0;
          bitpos <= ROOT_W'(1) << (ROOT_W - 2);
        end
      end
      S_SQRT: begin
        if (!alu_rsp.borrow) begin
          v    <= alu_rsp.res[ROOT_W-1:0];
          root <= (root >> 1) | bitpos;
        end else begin
          root <= root >> 1;
        end
        bitpos <= bitpos >> 2;
        step   <= step + STEP_W'(1);
      end
      S_MUL: p  <= alu_rsp.prod[P_W-1:0];
      S_ADD: r0 <= alu_rsp.res[R0_W-1:0];
      S_CMP: begin
        level_q <= (q_fin > Q_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : q_fin[LEVEL_W-1:0];
      end
      default: level_q <= level_q;
    endcase
  end

endmodule

[design/windowed_rms_level_meter.sv]
// Windowed RMS level meter, top level.
// A sample that leaves the window open is squared and added; the next item is taken after that.
// A window close runs square, add, a 40-step divide and a 16-step root through the
// one shared adder/subtractor, 3 scaling steps and the hand-off; the level reaches the output
// register at the hand-off. A clear goes straight to the hand-off with level 0. A finished
// level waits in the output register while the next item is taken. Synchronous reset clears
// the sequencer, the window sum and count, and the output valid.
module windowed_rms_level_meter import wrlm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           command,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [LEVEL_W-1:0]         level
);

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic               res_valid;
  logic [LEVEL_W-1:0] res_level;
  logic               res_stall;

  wrlm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .sample    (sample),
    .alu_req   (alu_req),
    .alu_rsp   (alu_rsp),
    .res_valid (res_valid),
    .res_level (res_level),
    .res_stall (res_stall)
  );

  wrlm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  wrlm_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_level (res_level),
    .res_stall (res_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .level     (level)
  );

endmodule

[design/wrlm_checker.sv]
// Port-level checks for the windowed RMS level meter, bound to the top level.
// Depends on wrlm_pkg.
module wrlm_checker import wrlm_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [CMD_W-1:0]           command,
  input logic signed [SAMPLE_W-1:0] sample,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [LEVEL_W-1:0]         level
);

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(level))
    else $error("output level changed while stalled");

  // Level never exceeds full scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level <= LEVEL_W'(LEVEL_MAX))
    else $error("level above 1000");

  // The sequencer is busy in the cycle after every accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again in the cycle after an item");

endmodule

bind windowed_rms_level_meter wrlm_checker u_wrlm_checker (.*);

[tb/sv/wrlm_level_checker.sv]
// Level checker for the windowed RMS level meter testbench.
// Watches both channels, predicts each window's level and compares it with what the block emits.
// Depends on wrlm_pkg for widths, scaling constants and command codes.
module wrlm_level_checker import wrlm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [CMD_W-1:0]           command,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [LEVEL_W-1:0]         level,
  output int                         mismatches,
  output int                         outstanding,
  output int                         checked
);

  timeunit 1ns;
  timeprecision 1ps;

  // Open window as the block should hold it
  logic [SUM_W-1:0]   energy;
  logic [CNT_W-1:0]   depth;
  logic [LEVEL_W-1:0] levels_due[$];

  logic signed [SAMPLE_W:0] wide;
  logic [SAMPLE_W:0]        mag;
  logic [LEVEL_W-1:0]       want;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    checked     = 0;
    energy      = '0;
    depth       = '0;
  end

  // Floor square root, built up one result bit at a time from the top
  function automatic logic [16:0] floor_root(input logic [31:0] v);
    logic [16:0] r;
    logic [16:0] t;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (17'd1 << b);
      if (64'(t) * 64'(t) <= 64'(v)) r = t;
    end
    return r;
  endfunction

  // Mean square, root, scale to thousandths of full scale, saturate
  function automatic logic [LEVEL_W-1:0] window_level(input logic [SUM_W-1:0] sum,
                                                      input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] mean;
    logic [16:0]      r;
    logic [31:0]      scaled;
    mean   = sum / SUM_W'(n);
    r      = floor_root(mean[31:0]);
    scaled = (32'(r) * LEVEL_MAX) / FULL_SCALE;
    if (scaled > LEVEL_MAX) scaled = LEVEL_MAX;
    return scaled[LEVEL_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 20) $display("[%0t] level check: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      energy = '0;
      depth  = '0;
      levels_due.delete();
    end else begin
      // Predict the level, if any, that an accepted item causes
      if (in_valid && !in_stall) begin
        if (command == CMD_ACC || command == CMD_CLOSE) begin
          wide   = sample;
          mag    = (wide < 0) ? -wide : wide;
          energy = energy + SUM_W'(mag) * SUM_W'(mag);
          depth  = depth + 1'b1;
          if (command == CMD_CLOSE || depth >= MAX_WINDOW) begin
            levels_due.push_back(window_level(energy, depth));
            energy = '0;
            depth  = '0;
          end
        end else begin
          // Clear and the unused code drop the window and report silence
          levels_due.push_back('0);
          energy = '0;
          depth  = '0;
        end
      end
      // Compare an emitted level with the oldest prediction
      if (out_valid && !out_stall) begin
        checked++;
        if (levels_due.size() == 0) begin
          report_mismatch($sformatf("level %0d emitted with none pending", level));
        end else begin
          want = levels_due.pop_front();
          if (level !== want)
            report_mismatch($sformatf("level %0d, predicted %0d", level, want));
        end
      end
    end
    outstanding <= levels_due.size();
  end

endmodule

[tb/sv/tb_windowed_rms_level_meter.sv]
// Top of the windowed RMS level meter testbench.
// Drives sample items and output stalls, and gives the verdict from the level checker's count.
// Depends on wrlm_pkg, windowed_rms_level_meter and wrlm_level_checker.
module tb_windowed_rms_level_meter import wrlm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Unused command code, handled by the block like a clear
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1850;
  localparam int QUIET_FROM  = 1700;
  localparam int HOLD_CYCLES = 400;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [CMD_W-1:0]           command = CMD_ACC;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [LEVEL_W-1:0]         level;

  int mismatches;
  int outstanding;
  int checked;

  int items_in    = 0;
  int closes_sent = 0;
  int clears_sent = 0;
  bit quiet       = 1'b0;
  bit held_long   = 1'b0;

  always #2 clk = ~clk;

  windowed_rms_level_meter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .level     (level)
  );

  wrlm_level_checker u_level_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .level       (level),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // Offer one item, after an optional idle burst, and hold it until accepted
  task automatic offer(input logic [CMD_W-1:0] c, input logic signed [SAMPLE_W-1:0] s);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    sample   <= s;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    items_in++;
    if (c == CMD_CLOSE) closes_sent++;
    if (c == CMD_CLEAR || c == CMD_SPARE) clears_sent++;
    if (items_in >= QUIET_FROM) quiet = 1'b1;
  endtask

  // Random sample, shrunk toward zero by an arithmetic shift to spread the levels
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int shift);
    logic signed [SAMPLE_W-1:0] raw;
    raw = SAMPLE_W'($urandom);
    return raw >>> shift;
  endfunction

  // Sender: directed windows first, then random windows
  initial begin
    int len;
    int shift;
    int kind;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Single-sample windows at the extremes; the most negative sample reads exactly full scale
    offer(CMD_CLOSE, 16'sd0);
    offer(CMD_CLOSE, 16'sd32767);
    offer(CMD_CLOSE, -16'sd32768);
    offer(CMD_CLOSE, -16'sd1);
    // Mixed window
    offer(CMD_ACC, 16'sd32767);
    offer(CMD_ACC, -16'sd32768);
    offer(CMD_CLOSE, 16'sd0);
    // Clear drops a partial window and ignores its sample
    offer(CMD_ACC, 16'sd1234);
    offer(CMD_CLEAR, -16'sd32768);
    offer(CMD_CLOSE, 16'sd100);
    // Unused code acts as a clear
    offer(CMD_ACC, 16'sd5000);
    offer(CMD_SPARE, 16'sd32767);
    offer(CMD_CLOSE, -16'sd20000);
    // Clear of an empty window
    offer(CMD_CLEAR, 16'sd0);
    offer(CMD_SPARE, -16'sd1);
    // Alternating bit patterns
    offer(CMD_ACC, 16'sh5555);
    offer(CMD_ACC, 16'shAAAA);
    offer(CMD_CLOSE, 16'sh7FFF);
    offer(CMD_ACC, -16'sd32767);
    offer(CMD_CLOSE, 16'sd1);

    // One window that runs into the size limit and closes on its own
    len = MAX_WINDOW + $urandom_range(0, 20);
    for (int i = 0; i < len; i++) offer(CMD_ACC, pick_sample(0));
    offer(CMD_CLOSE, pick_sample(0));

    // Mostly well-formed short windows, some noise and broken windows
    while (items_in < ITEM_TARGET) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        offer(CMD_W'($urandom_range(0, 3)), pick_sample(0));
      end else if (kind == 1) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) offer(CMD_ACC, pick_sample($urandom_range(0, 15)));
        offer($urandom_range(0, 1) ? CMD_CLEAR : CMD_SPARE, pick_sample(0));
      end else begin
        len   = $urandom_range(0, 40);
        shift = $urandom_range(0, 15);
        for (int i = 0; i < len; i++) offer(CMD_ACC, pick_sample(shift));
        offer(CMD_CLOSE, pick_sample(shift));
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow a window close worth of cycles for stray levels
    do @(negedge clk); while (outstanding != 0);
    repeat (80) @(posedge clk);

    $display("summary: %0d items sent (%0d closes, %0d clears), %0d levels compared",
             items_in, closes_sent, clears_sent, checked);
    $display("summary: size-limit close and a %0d-cycle output hold covered", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("tb_windowed_rms_level_meter: clean");
    end else begin
      $display("tb_windowed_rms_level_meter: errors");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold to back up the block, none near the end
  initial begin
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (!held_long && items_in >= 1000) begin
        held_long = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("tb_windowed_rms_level_meter: errors");
    $finish;
  end

endmodule
